### rtl/decimal_text_to_integer_top_defines.svh
// ----------------------------------------------------------------------------
// Decimal text to integer: assertion macros
// Shared concurrent assertion forms used by the parser's checks.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_INTEGER_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_INTEGER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTOI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtoi: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DTOI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtoi: next-cycle check failed");

`endif

### rtl/dtoi_pkg.sv
// ----------------------------------------------------------------------------
// Decimal text to integer: package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dtoi_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CONSUMED_W      = 16;
    localparam int VALUE_W         = 64;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_SIGN    = 2'd1,
        PH_DIGITS  = 2'd2,
        PH_STOPPED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic {
        REG_WIDTH_SELECT = 1'b0,
        REG_SIGNED_MODE  = 1'b1
    } t_reg_index;

    localparam logic [1:0] WSEL_16 = 2'd0;
    localparam logic [1:0] WSEL_32 = 2'd1;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_W-1:0]    value_bits;
        logic [CONSUMED_W-1:0] consumed;
    } t_out_word;

    typedef struct packed {
        logic [1:0] width_select;
        logic       signed_mode;
    } t_cfg;

    // One classified byte as it travels from front to back.
    typedef struct packed {
        logic       is_digit;
        logic       is_minus;
        logic [3:0] digit;
        logic       last;
    } t_cls;

    // One finished parse before sign application.
    typedef struct packed {
        t_status               status;
        logic                  neg;
        logic [VALUE_W-1:0]    mag;
        logic [CONSUMED_W-1:0] consumed;
    } t_res;

endpackage

`default_nettype wire

### rtl/dtoi_fifo.sv
// ----------------------------------------------------------------------------
// Decimal text to integer: two-entry queue
// Small first-in first-out buffer that decouples producer and consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_fifo #(
    parameter int DATA_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/dtoi_front.sv
// ----------------------------------------------------------------------------
// Decimal text to integer: front end
// Takes in raw bytes and classifies them as digit, minus or other.
// ----------------------------------------------------------------------------
`default_nettype none

module dtoi_front (
    input  wire logic              i_push,
    input  wire dtoi_pkg::t_in_word i_word,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output dtoi_pkg::t_cls         o_cls
);

    logic [7:0] rel;

    // Offset from the code of zero; only meaningful for digits.
    assign rel = i_word.char_code - dtoi_pkg::CHAR_ZERO;

    always_comb begin
        o_cls.is_digit = (i_word.char_code >= dtoi_pkg::CHAR_ZERO) &&
                         (i_word.char_code <= dtoi_pkg::CHAR_NINE);
        o_cls.is_minus = (i_word.char_code == dtoi_pkg::CHAR_MINUS);
        o_cls.digit    = o_cls.is_digit ? rel[3:0] : 4'd0;
        o_cls.last     = i_word.end_of_buffer;
    end

    assign o_q_push = i_push && !i_q_full;

endmodule

`default_nettype wire

### rtl/dtoi_back.sv
// ----------------------------------------------------------------------------
// Decimal text to integer: back end
// Runs the parse state machine and range check, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_text_to_integer_top_defines.svh"

module dtoi_back #(
    parameter int COUNT_WIDTH = dtoi_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dtoi_pkg::t_cfg i_cfg,
    input  wire logic           i_cls_valid,
    input  wire dtoi_pkg::t_cls i_cls,
    output logic                o_cls_pop,
    input  wire logic           i_res_full,
    output logic                o_res_push,
    output dtoi_pkg::t_res      o_res
);

    localparam int CW_EXT = (COUNT_WIDTH > dtoi_pkg::CONSUMED_W) ?
                            COUNT_WIDTH : dtoi_pkg::CONSUMED_W;

    dtoi_pkg::t_phase        r_phase, n_phase;
    dtoi_pkg::t_status       r_status, n_status;
    logic [63:0]             r_acc, n_acc;
    logic                    r_neg, n_neg;
    logic [COUNT_WIDTH-1:0]  r_count, n_count;

    logic                    step;
    logic                    inv;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic [63:0]             lim;
    logic [67:0]             acc_ext;
    logic [67:0]             mac;
    logic                    over;
    logic [CW_EXT-1:0]       cnt_ext;

    // Largest magnitude allowed for the configured range and sign.
    always_comb begin
        case (i_cfg.width_select)
            dtoi_pkg::WSEL_16: begin
                lim = i_cfg.signed_mode ? (r_neg ? 64'h8000 : 64'h7FFF) : 64'hFFFF;
            end
            dtoi_pkg::WSEL_32: begin
                lim = i_cfg.signed_mode ? (r_neg ? 64'h8000_0000 : 64'h7FFF_FFFF)
                                        : 64'hFFFF_FFFF;
            end
            default: begin
                lim = i_cfg.signed_mode ?
                      (r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                      : 64'hFFFF_FFFF_FFFF_FFFF;
            end
        endcase
    end

    // Times ten by shift and add; the digit overflows when the sum passes the limit.
    assign acc_ext   = {4'b0000, r_acc};
    assign mac       = (acc_ext << 3) + (acc_ext << 1) + 68'(i_cls.digit);
    assign over      = (mac > {4'b0000, lim});
    assign count_inc = (r_count == '1) ? r_count : r_count + COUNT_WIDTH'(1);
    assign step      = i_cls_valid && !i_res_full;
    assign o_cls_pop = step;

    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_count  = r_count;
        inv      = 1'b0;

        case (r_phase)
            dtoi_pkg::PH_START: begin
                if (i_cls.is_minus) begin
                    if (i_cfg.signed_mode) begin
                        n_neg   = 1'b1;
                        n_count = count_inc;
                        n_phase = dtoi_pkg::PH_SIGN;
                    end else begin
                        inv = 1'b1;
                    end
                end else if (i_cls.is_digit) begin
                    n_acc   = 64'(i_cls.digit);
                    n_count = count_inc;
                    n_phase = dtoi_pkg::PH_DIGITS;
                end else begin
                    inv = 1'b1;
                end
            end
            dtoi_pkg::PH_SIGN: begin
                if (i_cls.is_digit) begin
                    n_acc   = 64'(i_cls.digit);
                    n_count = count_inc;
                    n_phase = dtoi_pkg::PH_DIGITS;
                end else begin
                    inv = 1'b1;
                end
            end
            dtoi_pkg::PH_DIGITS: begin
                if (i_cls.is_digit) begin
                    n_count = count_inc;
                    if (over) begin
                        n_status = dtoi_pkg::ST_RANGE;
                        n_phase  = dtoi_pkg::PH_STOPPED;
                    end else begin
                        n_acc = mac[63:0];
                    end
                end else begin
                    n_status = dtoi_pkg::ST_OK;
                    n_phase  = dtoi_pkg::PH_STOPPED;
                end
            end
            default: begin
            end
        endcase

        // A buffer that ends right after the sign holds no number.
        if (i_cls.last && (n_phase == dtoi_pkg::PH_SIGN)) begin
            inv = 1'b1;
        end
        if (inv) begin
            n_status = dtoi_pkg::ST_INVALID;
            n_count  = '0;
            n_phase  = dtoi_pkg::PH_STOPPED;
        end
        if (i_cls.last && (n_phase == dtoi_pkg::PH_DIGITS)) begin
            n_status = dtoi_pkg::ST_OK;
        end
    end

    assign cnt_ext = CW_EXT'(n_count);

    always_comb begin
        o_res_push      = step && i_cls.last;
        o_res.status    = n_status;
        o_res.neg       = n_neg;
        o_res.mag       = n_acc;
        o_res.consumed  = (cnt_ext > CW_EXT'(16'hFFFF)) ? 16'hFFFF
                                                         : cnt_ext[dtoi_pkg::CONSUMED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dtoi_pkg::PH_START;
            r_status <= dtoi_pkg::ST_OK;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_count  <= '0;
        end else if (step) begin
            if (i_cls.last) begin
                r_phase  <= dtoi_pkg::PH_START;
                r_status <= dtoi_pkg::ST_OK;
                r_acc    <= '0;
                r_neg    <= 1'b0;
                r_count  <= '0;
            end else begin
                r_phase  <= n_phase;
                r_status <= n_status;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_count  <= n_count;
            end
        end
    end

    `DTOI_ASSERT_IMP(a_push_needs_step, i_clk, i_rst_n, o_res_push, step && !i_res_full)
    `DTOI_ASSERT_NXT(a_restart_after_result, i_clk, i_rst_n, o_res_push,
                     (r_phase == dtoi_pkg::PH_START) && (r_count == '0))
    `DTOI_ASSERT_IMP(a_invalid_zero_count, i_clk, i_rst_n,
                     o_res_push && (o_res.status == dtoi_pkg::ST_INVALID),
                     o_res.consumed == '0)
    `DTOI_ASSERT_IMP(a_start_is_clean, i_clk, i_rst_n, r_phase == dtoi_pkg::PH_START,
                     (r_acc == '0) && !r_neg && (r_count == '0))

endmodule

`default_nettype wire

### rtl/decimal_text_to_integer_top.sv
// ----------------------------------------------------------------------------
// Decimal text to integer: top level
// Parses a byte stream of decimal text into a range-checked integer.
// ----------------------------------------------------------------------------
// Usage. Bytes of a text buffer enter one per word on the input queue: a word
// is taken at a clock edge where push is high and full is low. The word with
// end_of_buffer set closes the buffer and produces exactly one result word;
// other bytes produce none. Results leave through the output queue: the
// oldest result is shown while empty is low and is taken when pop is high.
// Throughput is one byte per cycle while the result queue has room, set by the
// combinational times-ten and add with range compare in the back end. A result
// becomes visible after the closing byte has passed through the byte queue and
// the parser has pushed its result into the result queue at the edge where it
// takes the byte. The sign is applied as the result leaves the queue. If the
// receiver stops popping, the result queue fills, the parser halts, the byte
// queue fills and full rises; no word is lost. Synchronous reset empties both
// queues, restarts the parse and sets the configuration to 32-bit signed.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data. The
// user must write it only while no buffer is in flight; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_integer_top #(
    parameter int COUNT_WIDTH = dtoi_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input queue side.
    input  wire logic                push,
    output logic                     full,
    input  wire dtoi_pkg::t_in_word  i_in_word,
    // Result queue side.
    output logic                     empty,
    input  wire logic                pop,
    output dtoi_pkg::t_out_word      o_out_word,
    // Configuration write port.
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [1:0]          i_cfg_data
);

    localparam int CLS_W = $bits(dtoi_pkg::t_cls);
    localparam int RES_W = $bits(dtoi_pkg::t_res);

    dtoi_pkg::t_cfg r_cfg;
    dtoi_pkg::t_cls front_cls;
    dtoi_pkg::t_cls back_cls;
    dtoi_pkg::t_res back_res;
    dtoi_pkg::t_res head_res;
    logic           q_push;
    logic           q_empty;
    logic           q_pop;
    logic           res_full;
    logic           res_push;
    logic [CLS_W-1:0] back_cls_bits;
    logic [RES_W-1:0] head_res_bits;

    // Configuration registers; a write to a register updates only that one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_select <= dtoi_pkg::WSEL_32;
            r_cfg.signed_mode  <= 1'b1;
        end else if (i_cfg_we) begin
            case (dtoi_pkg::t_reg_index'(i_cfg_index))
                dtoi_pkg::REG_WIDTH_SELECT: r_cfg.width_select <= i_cfg_data;
                dtoi_pkg::REG_SIGNED_MODE:  r_cfg.signed_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Front end: classify each byte and push it into the byte queue.
    dtoi_front u_front (
        .i_push   (push),
        .i_word   (i_in_word),
        .i_q_full (full),
        .o_q_push (q_push),
        .o_cls    (front_cls)
    );

    dtoi_fifo #(
        .DATA_W (CLS_W)
    ) u_byte_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (back_cls_bits),
        .o_empty (q_empty)
    );

    assign back_cls = dtoi_pkg::t_cls'(back_cls_bits);

    // Back end: parse state machine and range check.
    dtoi_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cls_valid (!q_empty),
        .i_cls       (back_cls),
        .o_cls_pop   (q_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    dtoi_fifo #(
        .DATA_W (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (head_res_bits),
        .o_empty (empty)
    );

    assign head_res = dtoi_pkg::t_res'(head_res_bits);

    // The value is the two's complement of the magnitude for negative input,
    // and zero whenever the parse did not succeed.
    always_comb begin
        o_out_word.status   = head_res.status;
        o_out_word.consumed = head_res.consumed;
        if (head_res.status != dtoi_pkg::ST_OK) begin
            o_out_word.value_bits = '0;
        end else if (head_res.neg) begin
            o_out_word.value_bits = '0 - head_res.mag;
        end else begin
            o_out_word.value_bits = head_res.mag;
        end
    end

endmodule

`default_nettype wire
